@@ hdl/bicubic_bezier_patch_evaluator_unit_macros.svh @@
// Assertion macros for the bicubic Bezier patch evaluator.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef BICUBIC_BEZIER_PATCH_EVALUATOR_UNIT_MACROS_SVH
`define BICUBIC_BEZIER_PATCH_EVALUATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define BBP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define BBP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BBP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/bbpe_pkg.sv @@
// Shared types and constants for the bicubic Bezier patch evaluator.
// No dependencies.
package bbpe_pkg;
    localparam int OUT_BITS = 40;
    localparam int W_BITS = 20;
    localparam logic [2:0] REQ_WRITE = 3'd0;
    localparam logic [2:0] REQ_POS   = 3'd1;
    localparam logic [2:0] REQ_DV    = 3'd2;
    localparam logic [2:0] REQ_DU    = 3'd3;
    localparam logic [2:0] REQ_DVDU  = 3'd4;
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;
    localparam logic [1:0] CFG_COLS = 2'd0;
    localparam logic [1:0] CFG_ROWS = 2'd1;
    localparam logic [1:0] CFG_WRAP = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic       load;     // capture item, start weight generation
        logic       wgt_step; // advance weight unit
        logic       rd_en;    // issue a point read
        logic [1:0] k1;
        logic [1:0] k2;
        logic       acc_clr;
        logic       acc_en;   // accumulate returned point
        logic       row_done; // finish a row pass
        logic       col_done; // finish the column pass
        logic       out_load;
        logic       out_bad;
    } bbpe_cmd_t;

    typedef struct packed {
        logic bad;
    } bbpe_sts_t;
endpackage

@@ hdl/bicubic_bezier_patch_evaluator_unit.sv @@
// Evaluates one bicubic Bezier patch at a time from a stored control-point grid.
// An evaluation is taken in one transfer and its result comes from weight
// generation, four rows of four point reads from the single read port of the
// point RAMs (each row followed by a drain and a finish state), the column
// pass over the four row totals and a result load. The input stalls for the
// whole evaluation and while a result waits, so a new item is taken at the
// earliest in the cycle the result is taken. A write is stored on its own transfer.
// A bad patch index goes straight from the transfer to the result load.
// Depends on bbpe_pkg, bbpe_ctrl and bbpe_datapath.
module bicubic_bezier_patch_evaluator_unit #(
    parameter int MAX_COLS = 8,
    parameter int MAX_ROWS = 8,
    parameter int COORD_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [3:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         req_type,
    input  logic [9:0]         point_index,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    input  logic [2:0]         patch_row,
    input  logic [2:0]         patch_col,
    input  logic [16:0]        param_v,
    input  logic [16:0]        param_u,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [39:0] out_x,
    output logic signed [39:0] out_y,
    output logic signed [39:0] out_z,
    output logic [1:0]         status
);
    logic [3:0] cols_reg, rows_reg;
    logic wrap_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= 4'd1;
            rows_reg <= 4'd1;
            wrap_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bbpe_pkg::CFG_COLS: cols_reg <= cfg_data;
                bbpe_pkg::CFG_ROWS: rows_reg <= cfg_data;
                bbpe_pkg::CFG_WRAP: wrap_reg <= cfg_data[0];
                default: wrap_reg <= wrap_reg;
            endcase
        end
    end

    bbpe_pkg::bbpe_cmd_t cmd;
    bbpe_pkg::bbpe_sts_t sts;
    logic wr_en;

    bbpe_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_type(req_type),
        .in_stall(in_stall), .wr_en(wr_en), .sts(sts), .cmd(cmd),
        .out_valid(out_valid), .out_stall(out_stall)
    );

    bbpe_datapath #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .COORD_BITS(COORD_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_index(point_index),
        .wr_x(coord_x), .wr_y(coord_y), .wr_z(coord_z), .in_type(req_type),
        .in_row(patch_row), .in_col(patch_col), .in_v(param_v), .in_u(param_u),
        .cols_cfg(cols_reg), .rows_cfg(rows_reg), .wrap_cfg(wrap_reg),
        .cmd(cmd), .sts(sts), .res_x(out_x), .res_y(out_y), .res_z(out_z),
        .res_status(status)
    );
endmodule

@@ hdl/bbpe_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bbpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 625
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hdl/bbpe_datapath.sv @@
// Datapath: point stores, Bernstein weight unit, row and column accumulation.
// Depends on bbpe_pkg and bbpe_ram.
`include "bicubic_bezier_patch_evaluator_unit_macros.svh"
module bbpe_datapath #(
    parameter int MAX_COLS = 8,
    parameter int MAX_ROWS = 8,
    parameter int COORD_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [9:0]          wr_index,
    input  logic signed [31:0]  wr_x,
    input  logic signed [31:0]  wr_y,
    input  logic signed [31:0]  wr_z,
    input  logic [2:0]          in_type,
    input  logic [2:0]          in_row,
    input  logic [2:0]          in_col,
    input  logic [16:0]         in_v,
    input  logic [16:0]         in_u,
    input  logic [3:0]          cols_cfg,
    input  logic [3:0]          rows_cfg,
    input  logic                wrap_cfg,
    input  bbpe_pkg::bbpe_cmd_t cmd,
    output bbpe_pkg::bbpe_sts_t sts,
    output logic signed [bbpe_pkg::OUT_BITS-1:0] res_x,
    output logic signed [bbpe_pkg::OUT_BITS-1:0] res_y,
    output logic signed [bbpe_pkg::OUT_BITS-1:0] res_z,
    output logic [1:0]          res_status
);
    localparam int GRID_W = 3 * MAX_COLS + 1;
    localparam int DEPTH = GRID_W * (3 * MAX_ROWS + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int CB = $clog2(MAX_COLS + 1);
    localparam int RB = $clog2(MAX_ROWS + 1);
    localparam int ACC = COORD_BITS + 24;
    localparam int WB = bbpe_pkg::W_BITS;

    // register-count clamping
    logic [CB-1:0] cols_c;
    logic [RB-1:0] rows_c;
    always_comb
    begin
        if (cols_cfg == 4'd0)
            cols_c = CB'(1);
        else if (32'(cols_cfg) > MAX_COLS)
            cols_c = CB'(MAX_COLS);
        else
            cols_c = CB'(cols_cfg);
        if (rows_cfg == 4'd0)
            rows_c = RB'(1);
        else if (32'(rows_cfg) > MAX_ROWS)
            rows_c = RB'(MAX_ROWS);
        else
            rows_c = RB'(rows_cfg);
    end

    assign sts.bad = (32'(in_row) >= 32'(rows_c)) || (32'(in_col) >= 32'(cols_c));

    // captured item
    logic [2:0] row_reg, col_reg;
    logic [16:0] tv_reg, tu_reg;
    logic dv_reg, du_reg;
    logic [CB-1:0] cols_reg;
    logic wrap_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            row_reg  <= in_row;
            col_reg  <= in_col;
            tv_reg   <= (in_v > 17'd65536) ? 17'd65536 : in_v;
            tu_reg   <= (in_u > 17'd65536) ? 17'd65536 : in_u;
            dv_reg   <= (in_type == bbpe_pkg::REQ_DV) || (in_type == bbpe_pkg::REQ_DVDU);
            du_reg   <= (in_type == bbpe_pkg::REQ_DU) || (in_type == bbpe_pkg::REQ_DVDU);
            cols_reg <= cols_c;
            wrap_reg <= wrap_cfg;
        end
    end

    // weight unit: squares and cross products of s and t first, then the four weights per parameter
    logic [16:0] sv, su;
    assign sv = 17'd65536 - tv_reg;
    assign su = 17'd65536 - tu_reg;
    logic [33:0] ssv_reg, tsv_reg, ttv_reg, ssu_reg, tsu_reg, ttu_reg;
    logic signed [WB-1:0] wv_reg [4];
    logic signed [WB-1:0] wu_reg [4];

    function automatic logic signed [WB-1:0] rnd32(input logic [51:0] p);
        logic [52:0] t;
        t = {1'b0, p} + 53'h80000000;
        return WB'(t[52:32]);
    endfunction
    function automatic logic signed [WB-1:0] rnd16(input logic signed [36:0] p);
        logic signed [36:0] t;
        t = p + 37'sd32768;
        return WB'(t >>> 16);
    endfunction

    logic [1:0] wstep_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wstep_reg <= 2'd0;
        else if (cmd.load)
            wstep_reg <= 2'd0;
        else if (cmd.wgt_step)
            wstep_reg <= wstep_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wgt_step)
        begin
            unique case (wstep_reg)
                2'd0:
                begin
                    ssv_reg <= 34'(sv * sv);
                    tsv_reg <= 34'(sv * tv_reg);
                    ttv_reg <= 34'(tv_reg * tv_reg);
                    ssu_reg <= 34'(su * su);
                    tsu_reg <= 34'(su * tu_reg);
                    ttu_reg <= 34'(tu_reg * tu_reg);
                end
                2'd1:
                begin
                    if (!dv_reg)
                    begin
                        wv_reg[0] <= rnd32(52'(ssv_reg * sv));
                        wv_reg[1] <= rnd32(52'(3 * tsv_reg * sv));
                        wv_reg[2] <= rnd32(52'(3 * tsv_reg * tv_reg));
                        wv_reg[3] <= rnd32(52'(ttv_reg * tv_reg));
                    end
                    else
                    begin
                        wv_reg[0] <= rnd16(-37'sd3 * $signed({3'b0, ssv_reg}));
                        wv_reg[1] <= rnd16(37'sd3 * ($signed({3'b0, ssv_reg})
                                     - $signed({2'b0, tsv_reg, 1'b0})));
                        wv_reg[2] <= rnd16(37'sd3 * ($signed({2'b0, tsv_reg, 1'b0})
                                     - $signed({3'b0, ttv_reg})));
                        wv_reg[3] <= rnd16(37'sd3 * $signed({3'b0, ttv_reg}));
                    end
                    if (!du_reg)
                    begin
                        wu_reg[0] <= rnd32(52'(ssu_reg * su));
                        wu_reg[1] <= rnd32(52'(3 * tsu_reg * su));
                        wu_reg[2] <= rnd32(52'(3 * tsu_reg * tu_reg));
                        wu_reg[3] <= rnd32(52'(ttu_reg * tu_reg));
                    end
                    else
                    begin
                        wu_reg[0] <= rnd16(-37'sd3 * $signed({3'b0, ssu_reg}));
                        wu_reg[1] <= rnd16(37'sd3 * ($signed({3'b0, ssu_reg})
                                     - $signed({2'b0, tsu_reg, 1'b0})));
                        wu_reg[2] <= rnd16(37'sd3 * ($signed({2'b0, tsu_reg, 1'b0})
                                     - $signed({3'b0, ttu_reg})));
                        wu_reg[3] <= rnd16(37'sd3 * $signed({3'b0, ttu_reg}));
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // address generation
    logic [CB-1:0] colx;
    logic [2:0] kk;
    logic [AW+8:0] addr_full;
    always_comb
    begin
        colx = CB'(col_reg);
        kk = {1'b0, cmd.k2};
        if (wrap_reg && (CB'(col_reg) == cols_reg - CB'(1)) && (cmd.k2 == 2'd3))
        begin
            colx = '0;
            kk = 3'd0;
        end
        addr_full = (AW + 9)'((3 * 32'(row_reg) + 32'(cmd.k1)) * (3 * 32'(cols_reg) + 1)
                    + 3 * 32'(colx) + 32'(kk));
    end
    logic [AW-1:0] raddr;
    assign raddr = (32'(addr_full) < DEPTH) ? AW'(addr_full) : '0;

    logic wr_ok;
    assign wr_ok = wr_en && (32'(wr_index) < DEPTH);
    logic [COORD_BITS-1:0] wdx, wdy, wdz, rdx, rdy, rdz;
    assign wdx = COORD_BITS'(64'(wr_x));
    assign wdy = COORD_BITS'(64'(wr_y));
    assign wdz = COORD_BITS'(64'(wr_z));

    bbpe_ram #(.WIDTH(COORD_BITS), .DEPTH(DEPTH)) u_ram_x
        (.clk(clk), .we(wr_ok), .waddr(AW'(wr_index)), .wdata(wdx), .raddr(raddr), .rdata(rdx));
    bbpe_ram #(.WIDTH(COORD_BITS), .DEPTH(DEPTH)) u_ram_y
        (.clk(clk), .we(wr_ok), .waddr(AW'(wr_index)), .wdata(wdy), .raddr(raddr), .rdata(rdy));
    bbpe_ram #(.WIDTH(COORD_BITS), .DEPTH(DEPTH)) u_ram_z
        (.clk(clk), .we(wr_ok), .waddr(AW'(wr_index)), .wdata(wdz), .raddr(raddr), .rdata(rdz));

    // rd_en is pipelined with its k2 so the returning word meets the right weight
    logic [1:0] k2_d_reg;
    always_ff @(posedge clk)
    begin
        k2_d_reg <= cmd.k2;
    end

    // combine: split value into hi (>>24) and lo (low 24 bits) parts
    logic signed [ACC-1:0] hi_x_reg, hi_y_reg, hi_z_reg;
    logic signed [47:0] lo_x_reg, lo_y_reg, lo_z_reg;
    logic signed [ACC-1:0] rowv_x_reg [4];
    logic signed [ACC-1:0] rowv_y_reg [4];
    logic signed [ACC-1:0] rowv_z_reg [4];
    logic [1:0] rsel_reg;
    logic signed [WB-1:0] wsel;
    logic signed [ACC-1:0] vx, vy, vz;

    always_comb
    begin
        wsel = cmd.col_done ? wu_reg[rsel_reg] : wv_reg[k2_d_reg];
        if (cmd.col_done)
        begin
            vx = rowv_x_reg[rsel_reg];
            vy = rowv_y_reg[rsel_reg];
            vz = rowv_z_reg[rsel_reg];
        end
        else
        begin
            vx = ACC'($signed(rdx));
            vy = ACC'($signed(rdy));
            vz = ACC'($signed(rdz));
        end
    end

    function automatic logic signed [ACC-1:0] hpart(input logic signed [ACC-1:0] v);
        return v >>> 24;
    endfunction
    function automatic logic signed [47:0] lpart(input logic signed [ACC-1:0] v);
        return $signed({24'd0, v[23:0]});
    endfunction
    function automatic logic signed [ACC-1:0] fin(input logic signed [ACC-1:0] h,
                                                  input logic signed [47:0] l);
        logic signed [47:0] t;
        t = (l + 48'sd32768) >>> 16;
        return (h <<< 8) + ACC'(t);
    endfunction

    logic signed [ACC-1:0] fx, fy, fz;
    assign fx = fin(hi_x_reg, lo_x_reg);
    assign fy = fin(hi_y_reg, lo_y_reg);
    assign fz = fin(hi_z_reg, lo_z_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsel_reg <= 2'd0;
        else if (cmd.load)
            rsel_reg <= 2'd0;
        else if (cmd.col_done)
            rsel_reg <= rsel_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_clr)
        begin
            hi_x_reg <= '0; hi_y_reg <= '0; hi_z_reg <= '0;
            lo_x_reg <= '0; lo_y_reg <= '0; lo_z_reg <= '0;
        end
        else if (cmd.acc_en || cmd.col_done)
        begin
            hi_x_reg <= hi_x_reg + ACC'(wsel * hpart(vx));
            hi_y_reg <= hi_y_reg + ACC'(wsel * hpart(vy));
            hi_z_reg <= hi_z_reg + ACC'(wsel * hpart(vz));
            lo_x_reg <= lo_x_reg + 48'(wsel * lpart(vx));
            lo_y_reg <= lo_y_reg + 48'(wsel * lpart(vy));
            lo_z_reg <= lo_z_reg + 48'(wsel * lpart(vz));
        end
        if (cmd.row_done)
        begin
            rowv_x_reg[cmd.k1] <= fx;
            rowv_y_reg[cmd.k1] <= fy;
            rowv_z_reg[cmd.k1] <= fz;
        end
    end

    // saturate and register the result
    localparam logic signed [ACC-1:0] HI = ACC'((64'sd1 <<< (bbpe_pkg::OUT_BITS - 1)) - 1);
    localparam logic signed [ACC-1:0] LO = -HI - 1;
    function automatic logic signed [bbpe_pkg::OUT_BITS-1:0] sat(
        input logic signed [ACC-1:0] v);
        if (v > HI)
            return bbpe_pkg::OUT_BITS'(HI);
        if (v < LO)
            return bbpe_pkg::OUT_BITS'(LO);
        return bbpe_pkg::OUT_BITS'(v);
    endfunction
    logic any_sat;
    assign any_sat = fx > HI || fx < LO || fy > HI || fy < LO || fz > HI || fz < LO;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.out_bad)
            begin
                res_x <= '0; res_y <= '0; res_z <= '0;
                res_status <= bbpe_pkg::ST_BAD;
            end
            else
            begin
                res_x <= sat(fx); res_y <= sat(fy); res_z <= sat(fz);
                res_status <= any_sat ? bbpe_pkg::ST_SAT : bbpe_pkg::ST_OK;
            end
        end
    end

    `BBP_ASSERT_IMP(a_no_clash, clk, rst_n, cmd.acc_clr, !cmd.acc_en && !cmd.col_done)
    `BBP_ASSERT_IMP(a_no_rdwr_mix, clk, rst_n, cmd.load, !cmd.acc_en)
    `BBP_ASSERT_NXT(a_wstep, clk, rst_n, cmd.load, wstep_reg == 2'd0)
endmodule

@@ hdl/bbpe_ctrl.sv @@
// Controller: sequences the weight unit, the sixteen point reads and both passes.
// Depends on bbpe_pkg.
`include "bicubic_bezier_patch_evaluator_unit_macros.svh"
module bbpe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [2:0]          in_type,
    output logic                in_stall,
    output logic                wr_en,
    input  bbpe_pkg::bbpe_sts_t sts,
    output bbpe_pkg::bbpe_cmd_t cmd,
    output logic                out_valid,
    input  logic                out_stall
);
    typedef enum logic [2:0] {S_IDLE, S_WGT, S_ROW, S_DRAIN, S_FIN, S_COL, S_OUT} state_t;
    state_t state_reg;
    logic [3:0] cnt_reg;
    logic out_valid_reg;
    logic bad_reg;

    logic take, is_eval;
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign take = in_valid && !in_stall;
    assign is_eval = (in_type == bbpe_pkg::REQ_POS) || (in_type == bbpe_pkg::REQ_DV)
                   || (in_type == bbpe_pkg::REQ_DU) || (in_type == bbpe_pkg::REQ_DVDU);
    assign wr_en = take && (in_type == bbpe_pkg::REQ_WRITE);
    assign out_valid = out_valid_reg;

    logic rd_d_reg;

    always_comb
    begin
        cmd = '0;
        cmd.load = take && is_eval;
        cmd.k1 = cnt_reg[3:2];
        cmd.k2 = cnt_reg[1:0];
        cmd.out_bad = bad_reg;
        unique case (state_reg)
            S_IDLE: cmd.acc_clr = 1'b0;
            S_WGT:  cmd.wgt_step = 1'b1;
            S_ROW:  cmd.rd_en = 1'b1;
            S_DRAIN: cmd.rd_en = 1'b0;
            S_FIN:  cmd.row_done = 1'b1;
            S_COL:  cmd.col_done = 1'b1;
            S_OUT:  cmd.out_load = 1'b1;
            default: cmd.rd_en = 1'b0;
        endcase
        // the word read last cycle comes back now
        cmd.acc_en = rd_d_reg && (state_reg == S_ROW || state_reg == S_DRAIN);
        if (state_reg == S_ROW && cnt_reg[1:0] == 2'd0)
            cmd.acc_clr = 1'b0;
        if (state_reg == S_FIN)
            cmd.k1 = cnt_reg[3:2] - 2'd1;
        if (state_reg == S_WGT && cnt_reg == 4'd1)
            cmd.acc_clr = 1'b1;
        // row total is stored this cycle; start the next pass from zero
        if (state_reg == S_FIN)
            cmd.acc_clr = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            bad_reg <= 1'b0;
            rd_d_reg <= 1'b0;
        end
        else
        begin
            rd_d_reg <= cmd.rd_en;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.load)
                    begin
                        bad_reg <= sts.bad;
                        cnt_reg <= '0;
                        state_reg <= sts.bad ? S_OUT : S_WGT;
                    end
                end
                S_WGT:
                begin
                    if (cnt_reg == 4'd1)
                    begin
                        cnt_reg <= '0;
                        state_reg <= S_ROW;
                    end
                    else
                        cnt_reg <= cnt_reg + 4'd1;
                end
                S_ROW:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg[1:0] == 2'd3)
                        state_reg <= S_DRAIN;
                end
                S_DRAIN: state_reg <= S_FIN;
                S_FIN:
                begin
                    // the accumulator clear for this state is driven in the command logic above
                    state_reg <= (cnt_reg == 4'd0) ? S_COL : S_ROW;
                end
                S_COL:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg[1:0] == 2'd3)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `BBP_ASSERT_IMP(a_one_job, clk, rst_n, state_reg != S_IDLE, in_stall)
    `BBP_ASSERT_NXT(a_out, clk, rst_n, state_reg == S_OUT, out_valid_reg)
    `BBP_ASSERT_IMP(a_wr_idle, clk, rst_n, wr_en, state_reg == S_IDLE)
endmodule

@@ dv/tb_bicubic_bezier_patch_evaluator_unit.sv @@
// Testbench for the bicubic Bezier patch evaluator: a directed table, then random traffic,
// each evaluation checked against a behavioral predictor kept inside this module.
// Depends on bbpe_pkg and bicubic_bezier_patch_evaluator_unit.
module tb_bicubic_bezier_patch_evaluator_unit;
    localparam int GRID = 625;

    typedef struct packed {
        logic [2:0]  rtype;
        logic [9:0]  idx;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [2:0]  prow;
        logic [2:0]  pcol;
        logic [16:0] pv;
        logic [16:0] pu;
    } req_t;

    typedef struct packed {
        logic [39:0] x;
        logic [39:0] y;
        logic [39:0] z;
        logic [1:0]  st;
    } eval_t;

    typedef struct {
        req_t  r;
        logic  has_exp;
        eval_t e;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [3:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [2:0] req_type;
    logic [9:0] point_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [2:0] patch_row;
    logic [2:0] patch_col;
    logic [16:0] param_v;
    logic [16:0] param_u;
    logic out_valid;
    logic out_stall;
    logic signed [39:0] out_x;
    logic signed [39:0] out_y;
    logic signed [39:0] out_z;
    logic [1:0] status;

    bicubic_bezier_patch_evaluator_unit u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .point_index(point_index), .coord_x(coord_x),
        .coord_y(coord_y), .coord_z(coord_z), .patch_row(patch_row),
        .patch_col(patch_col), .param_v(param_v), .param_u(param_u),
        .out_valid(out_valid), .out_stall(out_stall), .out_x(out_x),
        .out_y(out_y), .out_z(out_z), .status(status)
    );

    // predictor state
    longint grid_x[GRID];
    longint grid_y[GRID];
    longint grid_z[GRID];
    bit     written[GRID];
    int     cols_cfg;
    int     rows_cfg;
    bit     wrap_cfg;

    eval_t  eval_q[$];
    int     errors;
    int     n_eval;
    int     n_bad;
    int     n_sat;
    int     n_checked;
    bit     hold_long;
    bit     stim_done;

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        #200000000;
        $display("timeout at %0t", $time);
        $display("Mismatches found");
        $finish;
    end

    function automatic longint floor_shift(longint a, int n);
        return a >>> n;
    endfunction

    function automatic void bern_weights(longint t, bit deriv, output longint w[4]);
        longint s;
        longint a;
        longint b;
        longint c;
        if (t > 65536)
            t = 65536;
        s = 65536 - t;
        if (!deriv)
        begin
            w[0] = floor_shift(s * s * s + 64'sd2147483648, 32);
            w[1] = floor_shift(3 * s * s * t + 64'sd2147483648, 32);
            w[2] = floor_shift(3 * s * t * t + 64'sd2147483648, 32);
            w[3] = floor_shift(t * t * t + 64'sd2147483648, 32);
        end
        else
        begin
            a = s * s;
            b = 2 * s * t;
            c = t * t;
            w[0] = floor_shift(-3 * a + 32768, 16);
            w[1] = floor_shift(3 * (a - b) + 32768, 16);
            w[2] = floor_shift(3 * (b - c) + 32768, 16);
            w[3] = floor_shift(3 * c + 32768, 16);
        end
    endfunction

    // weighted sum split in high and low parts to stay within 64 bits
    function automatic longint blend4(longint v[4], longint w[4]);
        longint hs;
        longint ls;
        longint hi;
        hs = 0;
        ls = 0;
        for (int i = 0; i < 4; i++)
        begin
            hi = floor_shift(v[i], 24);
            hs += w[i] * hi;
            ls += w[i] * (v[i] - hi * 64'sd16777216);
        end
        return hs * 256 + floor_shift(ls + 32768, 16);
    endfunction

    function automatic bit patch_ok(int pr, int pc);
        return pr < rows_cfg && pc < cols_cfg;
    endfunction

    // apply one request to the point grid; return 1 with the expected result
    function automatic bit eval_patch(req_t r, output eval_t e);
        longint wv[4];
        longint wu[4];
        longint pts[4];
        longint rv[4];
        longint res;
        longint hi_lim;
        int     width;
        int     col;
        int     kk;
        int     id;
        bit     sat;
        logic [39:0] o[3];
        hi_lim = (64'sd1 <<< 39) - 1;
        e = '0;
        if (r.rtype == bbpe_pkg::REQ_WRITE)
        begin
            if (r.idx < GRID)
            begin
                grid_x[r.idx] = longint'(signed'(r.cx));
                grid_y[r.idx] = longint'(signed'(r.cy));
                grid_z[r.idx] = longint'(signed'(r.cz));
                written[r.idx] = 1'b1;
            end
            return 1'b0;
        end
        if (r.rtype > bbpe_pkg::REQ_DVDU)
            return 1'b0;
        if (!patch_ok(r.prow, r.pcol))
        begin
            e.st = bbpe_pkg::ST_BAD;
            return 1'b1;
        end
        bern_weights(r.pv, r.rtype == bbpe_pkg::REQ_DV || r.rtype == bbpe_pkg::REQ_DVDU, wv);
        bern_weights(r.pu, r.rtype == bbpe_pkg::REQ_DU || r.rtype == bbpe_pkg::REQ_DVDU, wu);
        width = 3 * cols_cfg + 1;
        sat = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            for (int k1 = 0; k1 < 4; k1++)
            begin
                for (int k2 = 0; k2 < 4; k2++)
                begin
                    col = r.pcol;
                    kk = k2;
                    if (wrap_cfg && col == cols_cfg - 1 && kk == 3)
                    begin
                        col = 0;
                        kk = 0;
                    end
                    id = (3 * r.prow + k1) * width + 3 * col + kk;
                    pts[k2] = (id >= GRID) ? 0 : (c == 0 ? grid_x[id] :
                              (c == 1 ? grid_y[id] : grid_z[id]));
                end
                rv[k1] = blend4(pts, wv);
            end
            res = blend4(rv, wu);
            if (res > hi_lim)
            begin
                res = hi_lim;
                sat = 1'b1;
            end
            else if (res < -hi_lim - 1)
            begin
                res = -hi_lim - 1;
                sat = 1'b1;
            end
            o[c] = res[39:0];
        end
        e.x = o[0];
        e.y = o[1];
        e.z = o[2];
        e.st = sat ? bbpe_pkg::ST_SAT : bbpe_pkg::ST_OK;
        return 1'b1;
    endfunction

    task automatic idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return;
        else if (r < 95)
            repeat ($urandom_range(1, 3)) @(posedge clk);
        else
            repeat ($urandom_range(10, 60)) @(posedge clk);
    endtask

    // issue one item and hold it until accepted; queue the prediction at transfer
    task automatic send_item(req_t r, bit has_exp, eval_t ex);
        eval_t e;
        bit    got;
        in_valid    <= 1'b1;
        req_type    <= r.rtype;
        point_index <= r.idx;
        coord_x     <= r.cx;
        coord_y     <= r.cy;
        coord_z     <= r.cz;
        patch_row   <= r.prow;
        patch_col   <= r.pcol;
        param_v     <= r.pv;
        param_u     <= r.pu;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        got = eval_patch(r, e);
        if (got)
        begin
            if (has_exp && e != ex)
            begin
                errors++;
                $display("%0t table row disagrees with predictor: expected %h got %h",
                         $time, ex, e);
            end
            eval_q = {eval_q, (has_exp ? ex : e)};
            n_eval++;
            if (e.st == bbpe_pkg::ST_BAD)
                n_bad++;
            if (e.st == bbpe_pkg::ST_SAT)
                n_sat++;
        end
        if ($urandom_range(0, 99) < 40)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            idle_gap();
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (eval_q.size() != 0)
            @(posedge clk);
        // writes and ignored items finish quickly; leave slack anyway
        repeat (40) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[3:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (idx == bbpe_pkg::CFG_COLS)
            cols_cfg = val < 1 ? 1 : (val > 8 ? 8 : val);
        else if (idx == bbpe_pkg::CFG_ROWS)
            rows_cfg = val < 1 ? 1 : (val > 8 ? 8 : val);
        else
            wrap_cfg = val[0];
    endtask

    function automatic req_t mk_write(int idx, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z);
        req_t r;
        r = '0;
        r.rtype = bbpe_pkg::REQ_WRITE;
        r.idx = 10'(idx);
        r.cx = x;
        r.cy = y;
        r.cz = z;
        return r;
    endfunction

    function automatic req_t mk_eval(logic [2:0] t, int pr, int pc, int v, int u);
        req_t r;
        r = '0;
        r.rtype = t;
        r.prow = 3'(pr);
        r.pcol = 3'(pc);
        r.pv = 17'(v);
        r.pu = 17'(u);
        r.idx = 10'($urandom);
        r.cx = $urandom;
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 32'h7fffffff;
        if (k == 1)
            return 32'h80000000;
        if (k < 5)
            return $urandom;
        return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endfunction

    function automatic int rand_param();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 0;
        if (k == 1)
            return 65536;
        if (k == 2)
            return $urandom_range(65537, 131071);
        return $urandom_range(0, 65536);
    endfunction

    // fill every point used by the current layout so no read hits an unwritten entry
    task automatic fill_grid(bit extreme);
        int w;
        int h;
        w = 3 * cols_cfg + 1;
        h = 3 * rows_cfg + 1;
        for (int i = 0; i < w * h; i++)
        begin
            if (extreme)
                send_item(mk_write(i, (i & 1) ? 32'h7fffffff : 32'h80000000,
                          32'h7fffffff, 32'h80000000), 1'b0, '0);
            else
                send_item(mk_write(i, rand_coord(), rand_coord(), rand_coord()),
                          1'b0, '0);
        end
    endtask

    task automatic random_eval();
        req_t  r;
        int    k;
        int    w;
        int    h;
        k = $urandom_range(0, 99);
        w = 3 * cols_cfg + 1;
        h = 3 * rows_cfg + 1;
        if (k < 15)
            r = mk_write($urandom_range(0, w * h - 1), rand_coord(), rand_coord(),
                         rand_coord());
        else if (k < 18)
            // out-of-grid write index, dropped by the block
            r = mk_write($urandom_range(GRID, 1023), $urandom, $urandom, $urandom);
        else if (k < 21)
            r = mk_eval(3'($urandom_range(5, 7)), $urandom_range(0, 7),
                        $urandom_range(0, 7), $urandom, $urandom);
        else if (k < 28)
            r = mk_eval(3'($urandom_range(1, 4)), $urandom_range(0, 7),
                        $urandom_range(0, 7), $urandom_range(0, 131071),
                        $urandom_range(0, 131071));
        else
            r = mk_eval(3'($urandom_range(1, 4)), $urandom_range(0, rows_cfg - 1),
                        $urandom_range(0, cols_cfg - 1), rand_param(), rand_param());
        // a bad patch index never reads the grid, so it may go anywhere
        if (r.rtype >= bbpe_pkg::REQ_POS && r.rtype <= bbpe_pkg::REQ_DVDU
            && patch_ok(r.prow, r.pcol)
            && (3 * r.prow + 3) * w + 3 * r.pcol + 3 >= GRID)
            r.prow = 3'd0;
        send_item(r, 1'b0, '0);
    endtask

    // result checker
    always @(posedge clk)
    begin
        eval_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (eval_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none got %h %h %h %0d",
                         $time, out_x, out_y, out_z, status);
            end
            else
            begin
                e = eval_q.pop_front();
                n_checked++;
                if (out_x !== e.x)
                begin
                    errors++;
                    $display("%0t out_x: expected %h got %h", $time, e.x, out_x);
                end
                if (out_y !== e.y)
                begin
                    errors++;
                    $display("%0t out_y: expected %h got %h", $time, e.y, out_y);
                end
                if (out_z !== e.z)
                begin
                    errors++;
                    $display("%0t out_z: expected %h got %h", $time, e.z, out_z);
                end
                if (status !== e.st)
                begin
                    errors++;
                    $display("%0t status: expected %0d got %0d", $time, e.st, status);
                end
            end
        end
    end

    // receiver stalls; one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        while (1)
        begin
            @(posedge clk);
            if (hold_long)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                out_stall <= 1'b0;
                hold_long = 1'b0;
            end
            else if (stim_done || $urandom_range(0, 99) < 60)
                out_stall <= 1'b0;
            else if ($urandom_range(0, 99) < 92)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(0, 2)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(10, 50)) @(posedge clk);
            end
        end
    end

    initial
    begin
        row_t  dir[$];
        row_t  rw;
        int    lay[4][3];
        int    guard;
        errors = 0;
        n_eval = 0;
        n_bad = 0;
        n_sat = 0;
        n_checked = 0;
        hold_long = 1'b0;
        stim_done = 1'b0;
        cols_cfg = 1;
        rows_cfg = 1;
        wrap_cfg = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = bbpe_pkg::CFG_COLS;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = bbpe_pkg::REQ_WRITE;
        point_index = '0;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        patch_row = '0;
        patch_col = '0;
        param_v = '0;
        param_u = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset layout (one patch, 4x4 points)
        for (int i = 0; i < 16; i++)
        begin
            rw.r = mk_write(i, (i == 5) ? 32'h80000000 : 32'h7fffffff, 32'h00010000,
                            32'h0);
            rw.has_exp = 1'b0;
            rw.e = '0;
            dir = {dir, rw};
        end
        // corner at v=0,u=0 is point 0
        rw.r = mk_eval(bbpe_pkg::REQ_POS, 0, 0, 0, 0);
        rw.has_exp = 1'b1;
        rw.e = '{x: 40'h007fffffff, y: 40'h0000010000, z: 40'h0, st: bbpe_pkg::ST_OK};
        dir = {dir, rw};
        rw.r = mk_eval(bbpe_pkg::REQ_DV, 0, 0, 65536, 131071);
        rw.has_exp = 1'b0;
        dir = {dir, rw};
        rw.r = mk_eval(bbpe_pkg::REQ_DU, 0, 0, 32768, 0);
        dir = {dir, rw};
        rw.r = mk_eval(bbpe_pkg::REQ_DVDU, 0, 0, 131071, 12345);
        dir = {dir, rw};
        rw.r = mk_eval(bbpe_pkg::REQ_POS, 7, 7, 0, 0);
        rw.has_exp = 1'b1;
        rw.e = '{x: 40'h0, y: 40'h0, z: 40'h0, st: bbpe_pkg::ST_BAD};
        dir = {dir, rw};
        rw.r = mk_eval(3'd7, 0, 0, 0, 0);
        rw.has_exp = 1'b0;
        dir = {dir, rw};
        rw.r = mk_write(1023, 32'h1, 32'h1, 32'h1);
        dir = {dir, rw};
        foreach (dir[i])
            send_item(dir[i].r, dir[i].has_exp, dir[i].e);
        drain();

        // layouts: extremes, wrap both ways, out-of-range register values
        lay = '{'{8, 8, 0}, '{1, 1, 1}, '{15, 0, 1}, '{3, 5, 0}};
        for (int p = 0; p < 4; p++)
        begin
            write_cfg(bbpe_pkg::CFG_COLS, lay[p][0]);
            write_cfg(bbpe_pkg::CFG_ROWS, lay[p][1]);
            write_cfg(bbpe_pkg::CFG_WRAP, lay[p][2]);
            fill_grid(p == 0);
            if (p == 0)
            begin
                // saturation: all points at extremes, derivative weights of 3
                send_item(mk_eval(bbpe_pkg::REQ_DV, 0, 0, 0, 0), 1'b0, '0);
                send_item(mk_eval(bbpe_pkg::REQ_DVDU, 7, 7, 65536, 65536), 1'b0, '0);
                send_item(mk_eval(bbpe_pkg::REQ_DU, 3, 7, 0, 65536), 1'b0, '0);
            end
            if (p == 1)
                hold_long = 1'b1;
            for (int i = 0; i < 270; i++)
                random_eval();
            drain();
        end

        stim_done = 1'b1;
        guard = 0;
        while (eval_q.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (60) @(posedge clk);
        $display("covered %0d evaluations (%0d bad patch, %0d saturated), %0d results checked",
                 n_eval, n_bad, n_sat, n_checked);
        if (errors == 0 && eval_q.size() == 0)
            $display("No mismatches found");
        else
        begin
            if (eval_q.size() != 0)
                $display("%0t %0d results never arrived", $time, eval_q.size());
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
